### sv/cbm_pkg.sv
`default_nettype none

package cbm_pkg;

  // Sizing
  localparam int STACK_DEPTH = 256;
  localparam int LINE_WIDTH  = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
  localparam int OUT_LINE_W  = 16;

  // Character codes
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_NL     = 8'h0A;

  // Bracket codes: bit 0 set for closers, bit 1 set for parentheses
  localparam logic [1:0] BR_LBRACE = 2'd0;
  localparam logic [1:0] BR_RBRACE = 2'd1;
  localparam logic [1:0] BR_LPAREN = 2'd2;
  localparam logic [1:0] BR_RPAREN = 2'd3;

  // Verdict status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNMATCH  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Result kind
  localparam logic RES_ECHO    = 1'b0;
  localparam logic RES_VERDICT = 1'b1;

  // Item kind
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Lexer event handed to the stack unit
  typedef struct packed {
    logic                  valid;
    logic                  is_end;
    logic                  is_br;
    logic [1:0]            br;
    logic [LINE_WIDTH-1:0] line;
  } lex_ev_t;

  // One stack entry
  typedef struct packed {
    logic                  paren;
    logic [LINE_WIDTH-1:0] line;
  } stk_entry_t;

  // Result payload
  typedef struct packed {
    logic                  result_kind;
    logic [1:0]            bracket;
    logic [OUT_LINE_W-1:0] line;
    logic [1:0]            status;
  } res_t;

endpackage

`default_nettype wire

### sv/cbm_in_if.sv
`default_nettype none

interface cbm_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_req;

  modport source (output valid, output kind, output byte_req, input ready);
  modport sink   (input valid, input kind, input byte_req, output ready);
endinterface

`default_nettype wire

### sv/cbm_out_if.sv
`default_nettype none

interface cbm_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [1:0]  bracket;
  logic [15:0] line;
  logic [1:0]  status;

  modport source (output valid, output result_kind, output bracket, output line,
                  output status, input ready);
  modport sink   (input valid, input result_kind, input bracket, input line,
                  input status, output ready);
endinterface

`default_nettype wire

### sv/cbm_lexer.sv
`default_nettype none

module cbm_lexer (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            kind,
  input  logic [7:0]      byte_req,
  output cbm_pkg::lex_ev_t ev
);
  import cbm_pkg::*;

  localparam logic [2:0] M_CODE      = 3'd0;
  localparam logic [2:0] M_SLASH     = 3'd1;
  localparam logic [2:0] M_LINE_CMT  = 3'd2;
  localparam logic [2:0] M_BLK_FIRST = 3'd3;
  localparam logic [2:0] M_BLK       = 3'd4;
  localparam logic [2:0] M_BLK_STAR  = 3'd5;
  localparam logic [2:0] M_DQ        = 3'd6;
  localparam logic [2:0] M_SQ        = 3'd7;

  logic [2:0]            mode;
  logic [2:0]            mode_next;
  logic [LINE_WIDTH-1:0] line_count;
  logic [LINE_WIDTH-1:0] line_count_next;
  logic                  bump;
  logic                  code_path;
  logic                  is_br;
  logic [1:0]            br;

  // Lexer transition for one byte
  always_comb begin
    mode_next = mode;
    bump      = 1'b0;
    code_path = 1'b0;
    is_br     = 1'b0;
    br        = BR_LBRACE;
    case (mode)
      M_CODE: begin
        code_path = 1'b1;
      end
      M_SLASH: begin
        mode_next = M_CODE;
        if (byte_req == CH_SLASH) begin
          mode_next = M_LINE_CMT;
        end else if (byte_req == CH_STAR) begin
          mode_next = M_BLK_FIRST;
        end else begin
          code_path = 1'b1;
        end
      end
      M_LINE_CMT: begin
        if (byte_req == CH_NL) begin
          bump      = 1'b1;
          mode_next = M_CODE;
        end
      end
      M_BLK_FIRST, M_BLK: begin
        if (byte_req == CH_NL) begin
          bump      = 1'b1;
          mode_next = M_BLK;
        end else if (byte_req == CH_STAR) begin
          mode_next = M_BLK_STAR;
        end else begin
          mode_next = M_BLK;
        end
      end
      M_BLK_STAR: begin
        if (byte_req == CH_SLASH) begin
          mode_next = M_CODE;
        end else if (byte_req != CH_STAR) begin
          bump      = (byte_req == CH_NL);
          mode_next = M_BLK;
        end
      end
      M_DQ: begin
        if (byte_req == CH_NL) begin
          bump = 1'b1;
        end else if (byte_req == CH_DQUOTE) begin
          mode_next = M_CODE;
        end
      end
      default: begin
        if (byte_req == CH_NL) begin
          bump = 1'b1;
        end else if (byte_req == CH_SQUOTE) begin
          mode_next = M_CODE;
        end
      end
    endcase

    // Plain code byte
    if (code_path) begin
      if (byte_req == CH_LBRACE) begin
        is_br = 1'b1;
        br    = BR_LBRACE;
      end else if (byte_req == CH_RBRACE) begin
        is_br = 1'b1;
        br    = BR_RBRACE;
      end else if (byte_req == CH_LPAREN) begin
        is_br = 1'b1;
        br    = BR_LPAREN;
      end else if (byte_req == CH_RPAREN) begin
        is_br = 1'b1;
        br    = BR_RPAREN;
      end else if (byte_req == CH_NL) begin
        bump = 1'b1;
      end else if (byte_req == CH_SLASH) begin
        mode_next = M_SLASH;
      end else if (byte_req == CH_DQUOTE) begin
        mode_next = M_DQ;
      end else if (byte_req == CH_SQUOTE) begin
        mode_next = M_SQ;
      end
    end
  end

  // Saturating line counter
  always_comb begin
    line_count_next = line_count;
    if (bump && (line_count != '1)) begin
      line_count_next = line_count + LINE_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_CODE;
      line_count <= LINE_WIDTH'(1);
    end else if (accept) begin
      if (kind == KIND_END) begin
        mode       <= M_CODE;
        line_count <= LINE_WIDTH'(1);
      end else begin
        mode       <= mode_next;
        line_count <= line_count_next;
      end
    end
  end

  // Event toward the stack unit
  always_comb begin
    ev.valid  = accept;
    ev.is_end = (kind == KIND_END);
    ev.is_br  = (kind == KIND_BYTE) && is_br;
    ev.br     = br;
    ev.line   = line_count;
  end

endmodule

`default_nettype wire

### sv/cbm_stack.sv
`default_nettype none

module cbm_stack (
  input  logic             clk,
  input  logic             rst,
  input  cbm_pkg::lex_ev_t ev,
  output logic             res_valid,
  output cbm_pkg::res_t    res
);
  import cbm_pkg::*;

  stk_entry_t            mem [STACK_DEPTH];
  stk_entry_t            rd_data;
  stk_entry_t            top;
  stk_entry_t            bottom;
  stk_entry_t            new_ent;
  logic [FILL_W-1:0]     fill;
  logic [FILL_W-1:0]     fill_next;
  logic [FILL_W-1:0]     rd_ptr;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  err_seen;
  logic [1:0]            err_code;
  logic [1:0]            err_br;
  logic [LINE_WIDTH-1:0] err_line;
  logic                  push;
  logic                  pop;
  logic                  flag;
  logic [1:0]            f_code;
  logic [1:0]            f_br;
  logic [LINE_WIDTH-1:0] f_line;
  logic                  is_end;

  assign is_end = ev.valid && ev.is_end;

  // Bracket check and verdict
  always_comb begin
    push            = 1'b0;
    pop             = 1'b0;
    flag            = 1'b0;
    f_code          = ST_UNMATCH;
    f_br            = ev.br;
    f_line          = ev.line;
    new_ent.paren   = ev.br[1];
    new_ent.line    = ev.line;
    res_valid       = 1'b0;
    res.result_kind = RES_ECHO;
    res.bracket     = ev.br;
    res.line        = OUT_LINE_W'(ev.line);
    res.status      = ST_OK;
    if (is_end) begin
      res_valid       = 1'b1;
      res.result_kind = RES_VERDICT;
      if (err_seen) begin
        res.bracket = err_br;
        res.line    = OUT_LINE_W'(err_line);
        res.status  = err_code;
      end else if (fill == '0) begin
        res.bracket = BR_LBRACE;
        res.line    = '0;
        res.status  = ST_OK;
      end else begin
        res.bracket = bottom.paren ? BR_LPAREN : BR_LBRACE;
        res.line    = OUT_LINE_W'(bottom.line);
        res.status  = ST_UNMATCH;
      end
    end else if (ev.valid && ev.is_br) begin
      res_valid = 1'b1;
      if (!err_seen) begin
        if (!ev.br[0]) begin
          // opener
          if ((ev.br == BR_LBRACE) && (fill != '0) && top.paren) begin
            flag   = 1'b1;
            f_br   = BR_LPAREN;
            f_line = top.line;
          end else if (fill == FILL_W'(STACK_DEPTH)) begin
            flag   = 1'b1;
            f_code = ST_OVERFLOW;
          end else begin
            push = 1'b1;
          end
        end else begin
          // closer
          if ((fill == '0) || (top.paren != ev.br[1])) begin
            flag = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    fill_next = fill;
    if (is_end) begin
      fill_next = '0;
    end else if (push) begin
      fill_next = fill + FILL_W'(1);
    end else if (pop) begin
      fill_next = fill - FILL_W'(1);
    end
  end

  // Prefetch the entry just below the next top
  assign rd_ptr  = fill_next - FILL_W'(2);
  assign rd_addr = rd_ptr[ADDR_W-1:0];

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      err_seen <= 1'b0;
      err_code <= ST_OK;
      err_br   <= BR_LBRACE;
      err_line <= '0;
    end else begin
      fill <= fill_next;
      if (is_end) begin
        err_seen <= 1'b0;
        err_code <= ST_OK;
        err_br   <= BR_LBRACE;
        err_line <= '0;
      end else if (flag) begin
        err_seen <= 1'b1;
        err_code <= f_code;
        err_br   <= f_br;
        err_line <= f_line;
      end
    end
  end

  // Cached top and bottom entries
  always_ff @(posedge clk) begin
    if (push) begin
      top <= new_ent;
      if (fill == '0) begin
        bottom <= new_ent;
      end
    end else if (pop) begin
      top <= rd_data;
    end
  end

  // Stack memory
  always_ff @(posedge clk) begin
    if (push) begin
      mem[fill[ADDR_W-1:0]] <= new_ent;
    end
    rd_data <= mem[rd_addr];
  end

  // Fill moves by at most one per item, or clears at the end mark
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (fill == $past(fill)) || (fill == $past(fill) + FILL_W'(1)) ||
             (fill == $past(fill) - FILL_W'(1)) || (fill == '0))
    else $error("stack fill jumped");

  // Once an error is latched the stack is frozen until the end mark
  a_err_frozen: assert property (@(posedge clk) disable iff (rst)
    (err_seen && !is_end) |=> $stable(fill))
    else $error("stack changed after error");

  // End mark returns the checker to its reset state
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    is_end |=> (fill == '0) && !err_seen)
    else $error("end mark did not clear state");

  // Fill never exceeds the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    push |=> (fill <= FILL_W'(STACK_DEPTH)) && (fill != '0))
    else $error("stack fill out of range");

endmodule

`default_nettype wire

### sv/cbm_out_buf.sv
`default_nettype none

module cbm_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  cbm_pkg::res_t in_data,
  output logic          in_ready,
  cbm_out_if.source     rsp
);
  import cbm_pkg::*;

  logic out_valid;
  res_t out_data;
  logic skid_valid;
  res_t skid_data;

  assign in_ready = !skid_valid;

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !rsp.ready) begin
      if (in_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !rsp.ready) begin
      if (in_valid) begin
        skid_data <= in_data;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (in_valid) begin
      out_data <= in_data;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.result_kind = out_data.result_kind;
  assign rsp.bracket     = out_data.bracket;
  assign rsp.line        = out_data.line;
  assign rsp.status      = out_data.status;

  // Skid entry only fills behind a held output
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without output item");

endmodule

`default_nettype wire

### sv/c_bracket_matcher.sv
// A bracket echo or verdict item is registered in the output buffer before it appears on rsp.
// Throughput: one byte or end mark per cycle while req.ready is high; the top of stack sits
//   in flops and the entry below it is prefetched through the read port of the one-read,
//   one-write stack RAM every cycle, so pops never stall.
// rsp backpressure is absorbed by one skid entry; req.ready drops only while it is full.
// Reset (rst, synchronous): lexer to plain code, line to one, stack empty, no error latched;
//   the end mark returns the same state and stack RAM contents are never cleared.
`default_nettype none

module c_bracket_matcher (
  input  logic       clk,
  input  logic       rst,
  cbm_in_if.sink     req,
  cbm_out_if.source  rsp
);
  import cbm_pkg::*;

  logic    accept;
  logic    ready;
  lex_ev_t ev;
  logic    res_valid;
  res_t    res;

  assign req.ready = ready;
  assign accept    = req.valid && ready;

  cbm_lexer u_lexer (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .kind     (req.kind),
    .byte_req (req.byte_req),
    .ev       (ev)
  );

  cbm_stack u_stack (
    .clk       (clk),
    .rst       (rst),
    .ev        (ev),
    .res_valid (res_valid),
    .res       (res)
  );

  cbm_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_data  (res),
    .in_ready (ready),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire
